// ----- src/gpio_pin_access_with_mux_decode_top_defines.svh -----
// Assertion macros shared by the GPIO pin access checker.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef GPIO_PIN_ACCESS_WITH_MUX_DECODE_TOP_DEFINES_SVH
`define GPIO_PIN_ACCESS_WITH_MUX_DECODE_TOP_DEFINES_SVH

// Property checked on every clock edge outside reset.
`define GPMX_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("gpmx assertion failed");

// Property checked on every clock edge, reset included.
`define GPMX_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("gpmx reset assertion failed");

`endif

// ----- src/gpmx_pkg.sv -----
// Shared types, operation codes and pin decode functions for the GPIO pin access block.
// No dependencies; used by gpio_pin_access_with_mux_decode_top.
package gpmx_pkg;

    // Operation codes carried in the func field.
    localparam logic [2:0] FUNC_RD_LEVEL = 3'd0;
    localparam logic [2:0] FUNC_RD_DIR   = 3'd1;
    localparam logic [2:0] FUNC_WR_DIR   = 3'd2;
    localparam logic [2:0] FUNC_WR_DRIVE = 3'd3;
    localparam logic [2:0] FUNC_QRY_MODE = 3'd4;

    localparam logic [6:0] PIN_COUNT     = 7'd73;
    localparam logic [3:0] MODE_GPIO_OUT = 4'd8;
    localparam int         BANK_COUNT    = 4;
    localparam int         BANK_WIDTH    = 32;

    typedef logic [BANK_WIDTH-1:0] t_bank;

    // Bank and bit position of a valid pin.
    typedef struct packed {
        logic [1:0] bank;
        logic [4:0] bit_pos;
    } t_loc;

    // Group field and GPIO decision from the pin-mux word.
    typedef struct packed {
        logic [3:0] mode;
        logic       gpio;
    } t_mux;

    function automatic t_loc locate(input logic [6:0] pin);
        t_loc loc;
        logic [6:0] off;
        off = 7'd0;
        if (pin < 7'd24) begin
            loc.bank = 2'd0;
            off      = pin;
        end else if (pin < 7'd40) begin
            loc.bank = 2'd1;
            off      = pin - 7'd24;
        end else if (pin < 7'd72) begin
            loc.bank = 2'd2;
            off      = pin - 7'd40;
        end else begin
            loc.bank = 2'd3;
            off      = 7'd0;
        end
        loc.bit_pos = off[4:0];
        return loc;
    endfunction

    function automatic t_mux mux_decode(input logic [6:0] p, input logic [31:0] w);
        t_mux r;
        logic [2:0] m;
        m = 3'd0;
        r.gpio = 1'b0;
        if (p == 7'd0) begin
            r.gpio = 1'b1;
        end else if (p <= 7'd2) begin
            // I2C group.
            m      = {2'b00, w[0]};
            r.gpio = w[0];
        end else if ((p >= 7'd3 && p <= 7'd6) || (p >= 7'd37 && p <= 7'd39)) begin
            // SPI group: pins 38 and 39 are GPIO in every setting.
            m      = {1'b0, w[12:11]};
            r.gpio = w[11] || p == 7'd38 || p == 7'd39 ||
                     (p == 7'd37 && w[12:11] == 2'd3);
        end else if (p <= 7'd14) begin
            // UARTF group: lower and upper halves free up at different settings.
            m      = w[4:2];
            r.gpio = (m == 3'd7) || (p <= 7'd10 && m == 3'd4) ||
                     (p >= 7'd11 && m >= 3'd5);
        end else if (p <= 7'd16) begin
            m      = {2'b00, w[5]};
            r.gpio = w[5];
        end else if (p == 7'd17) begin
            m      = {1'b0, w[22:21]};
            r.gpio = (w[22:21] == 2'd2);
        end else if (p <= 7'd21) begin
            m      = {2'b00, w[20]};
            r.gpio = w[20];
        end else if (p <= 7'd23) begin
            m      = {1'b0, w[8:7]};
            r.gpio = (w[8:7] == 2'd2);
        end else if (p <= 7'd35) begin
            m      = {2'b00, w[9]};
            r.gpio = w[9];
        end else if (p == 7'd36) begin
            m      = {1'b0, w[16:15]};
            r.gpio = (w[16:15] == 2'd2);
        end else if (p <= 7'd44) begin
            m      = {2'b00, w[15]};
            r.gpio = w[15];
        end else if (p <= 7'd59) begin
            m      = {1'b0, w[16:15]};
            r.gpio = (w[16:15] == 2'd2);
        end else if (p <= 7'd71) begin
            m      = {2'b00, w[10]};
            r.gpio = w[10];
        end else begin
            m      = {2'b00, w[13]};
            r.gpio = w[13];
        end
        r.mode = {1'b0, m};
        return r;
    endfunction

endpackage

// ----- src/gpio_pin_access_with_mux_decode_top.sv -----
// Top level of the GPIO pin access block with pin-mux mode decode.
// Depends on gpmx_pkg for operation codes, pin location and mux decode.
//
// One pin access enters on the slave stream and one result leaves on the master
// stream for each transfer. The block takes one access per clock cycle while the
// master side keeps taking results. An access is loaded into the input register at
// its transfer edge, and its result is then loaded into the result register once
// that register can take data, from where it leaves on the master stream.
// Direction and drive bits update as the access moves from the input register to
// the result register, so back-to-back accesses to the same pin see each other's
// effects in order. Pins above 72 change nothing and return all zeros. The user
// must write the pin-mux word through i_cfg_we/i_cfg_wdata only while the block
// is idle; the block itself does not enforce this. The word resets to zero.
module gpio_pin_access_with_mux_decode_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Bits from the lowest up: func[2:0], pin[9:3], value[10], pad_level[11], zero[15:12].
    input  logic [15:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Bits from the lowest up: ok[0], level[1], is_output[2], mode[6:3], zero[7].
    output logic [7:0]  m_axis_tdata
);

    logic [31:0]        r_mux_word;
    gpmx_pkg::t_bank    r_dir [gpmx_pkg::BANK_COUNT];
    gpmx_pkg::t_bank    r_drv [gpmx_pkg::BANK_COUNT];

    logic               r_in_vld;
    logic [2:0]         r_func;
    logic [6:0]         r_pin;
    logic               r_value;
    logic               r_pad;

    logic               r_out_vld;
    logic [7:0]         r_out_data;

    logic               out_free;
    logic               move;
    logic               pin_ok;
    gpmx_pkg::t_loc     loc;
    gpmx_pkg::t_mux     mux;
    logic               dir_cur;
    logic               n_dir;
    logic               drv_cur;
    logic               n_level;
    logic [3:0]         n_mode;
    logic [7:0]         n_out_data;

    // Handshake: the input register drains whenever the result register can take data.
    assign out_free      = !r_out_vld || m_axis_tready;
    assign move          = r_in_vld && out_free;
    assign s_axis_tready = !r_in_vld || out_free;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mux_word <= 32'd0;
        end else if (i_cfg_we) begin
            r_mux_word <= i_cfg_wdata;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_func  <= s_axis_tdata[2:0];
            r_pin   <= s_axis_tdata[9:3];
            r_value <= s_axis_tdata[10];
            r_pad   <= s_axis_tdata[11];
        end
    end

    // Decode of the registered access against the current pin state.
    always_comb begin
        pin_ok  = (r_pin < gpmx_pkg::PIN_COUNT);
        loc     = gpmx_pkg::locate(r_pin);
        mux     = gpmx_pkg::mux_decode(r_pin, r_mux_word);
        dir_cur = r_dir[loc.bank][loc.bit_pos];
        drv_cur = r_drv[loc.bank][loc.bit_pos];
        n_dir   = (r_func == gpmx_pkg::FUNC_WR_DIR) ? r_value : dir_cur;
        n_level = 1'b0;
        n_mode  = 4'd0;
        case (r_func)
            gpmx_pkg::FUNC_RD_LEVEL: begin
                n_level = n_dir ? drv_cur : r_pad;
            end
            gpmx_pkg::FUNC_QRY_MODE: begin
                n_mode = (mux.gpio && n_dir) ? gpmx_pkg::MODE_GPIO_OUT : mux.mode;
            end
            default: begin
                n_level = 1'b0;
                n_mode  = 4'd0;
            end
        endcase
        if (pin_ok) begin
            n_out_data = {1'b0, n_mode, n_dir, n_level, 1'b1};
        end else begin
            n_out_data = 8'd0;
        end
    end

    // Pin state: direction and drive bits change as the access completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < gpmx_pkg::BANK_COUNT; b++) begin
                r_dir[b] <= '0;
                r_drv[b] <= '0;
            end
        end else if (move && pin_ok) begin
            if (r_func == gpmx_pkg::FUNC_WR_DIR) begin
                r_dir[loc.bank][loc.bit_pos] <= r_value;
            end else if (r_func == gpmx_pkg::FUNC_WR_DRIVE) begin
                r_drv[loc.bank][loc.bit_pos] <= r_value;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

// ----- src/gpmx_checker.sv -----
// Port-level checker for the GPIO pin access block, bound to the top level.
// Depends on gpio_pin_access_with_mux_decode_top_defines.svh for the assertion macros.
`include "gpio_pin_access_with_mux_decode_top_defines.svh"

module gpmx_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata
);

    // No result is presented in the cycle after reset.
    `GPMX_ASSERT_RST(a_rst_out_idle, !i_rst_n |=> !m_axis_tvalid)

    // A rejected pin returns an all-zero result.
    `GPMX_ASSERT(a_bad_pin_zero, m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata == 8'd0)

    // A level and a mode never come from the same access, and mode stays within range.
    `GPMX_ASSERT(a_level_mode_excl,
        m_axis_tvalid |-> (m_axis_tdata[1] == 1'b0 || m_axis_tdata[6:3] == 4'd0) &&
            m_axis_tdata[6:3] <= 4'd8 && !m_axis_tdata[7])

    // A stalled result holds.
    `GPMX_ASSERT(a_out_hold,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind gpio_pin_access_with_mux_decode_top gpmx_checker u_gpmx_checker (.*);
